### design/tccw_pkg.sv
// Shared constants, control-word types and microprogram table of the text console cursor writer.
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int COLUMNS = 40;
   localparam int CELLS   = 4800;
   localparam int ADDR_W  = 13;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int STEP_W  = 2;

   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] CR_CODE    = 8'd13;
   localparam logic [7:0] LF_CODE    = 8'd10;
   localparam logic [7:0] NUL_CODE   = 8'd0;

   // Datapath operation selected by a control word.
   typedef enum logic [1:0] {
      OP_TAKE    = 2'd0,
      OP_PUTC    = 2'd1,
      OP_NEWLINE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // Sequencing: how the next step is chosen.
   typedef enum logic [1:0] {
      SEQ_NEXT     = 2'd0,
      SEQ_JUMP     = 2'd1,
      SEQ_DISPATCH = 2'd2,
      SEQ_LOOP     = 2'd3
   } seq_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH   = 2'd0;
   localparam step_type STEP_PUTC    = 2'd1;
   localparam step_type STEP_NEWLINE = 2'd2;
   localparam step_type STEP_CLEAR   = 2'd3;

   typedef struct packed {
      op_type   op;
      logic     take;
      logic     emit;
      seq_type  seq;
      step_type target;
   } ctl_word_type;

   // The microprogram: fetch, then either one character write or a row set-up and a row clear.
   function automatic ctl_word_type rom_word(input step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_FETCH:   w = '{op: OP_TAKE,    take: 1'b1, emit: 1'b0,
                             seq: SEQ_DISPATCH, target: STEP_NEWLINE};
         STEP_PUTC:    w = '{op: OP_PUTC,    take: 1'b0, emit: 1'b1,
                             seq: SEQ_JUMP,  target: STEP_FETCH};
         STEP_NEWLINE: w = '{op: OP_NEWLINE, take: 1'b0, emit: 1'b0,
                             seq: SEQ_NEXT,  target: STEP_FETCH};
         STEP_CLEAR:   w = '{op: OP_CLEAR,   take: 1'b0, emit: 1'b1,
                             seq: SEQ_LOOP,  target: STEP_CLEAR};
         default:      w = '{op: OP_TAKE,    take: 1'b0, emit: 1'b0,
                             seq: SEQ_JUMP,  target: STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

### design/text_console_cursor_writer_top.sv
// Top level of the text console cursor writer: microcoded sequencer and cursor datapath.
`timescale 1ns / 1ps

// Usage
// The request channel (req_valid, req_stall, req_char_code) takes one character byte
// per beat. The response channel (rsp_valid, rsp_stall and the rsp_ payload) gives one
// cell write per beat for an external screen store of 40 columns by 120 rows.
// An ordinary byte gives a single write at the cursor, and the cursor moves on by one,
// wrapping to cell 0 after the last cell. A carriage return or line feed moves the
// cursor to the start of the next row (row 0 after the last) and gives 40 writes of a
// space that clear that row; only the final one carries rsp_last_write. A zero byte is
// taken and gives nothing.
// Sequencing: a byte is taken only in the fetch step of the microprogram. An ordinary
// byte passes through the fetch and write steps, a zero byte through fetch alone, and
// a newline through fetch, row set-up, then one clearing step for each of 40 writes.
// The step counter walks the control table one step per cycle while no write step is
// held. A write reaches the response port in the cycle after its step, from a single
// output register, so the next byte can be fetched while a finished write waits. With
// the register full and rsp_stall high, a write step holds until the register frees.
// Synchronous reset empties the output register, returns the sequencer to the fetch step
// and puts the cursor at cell 0.

module text_console_cursor_writer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_cell_address,
   output logic [7:0]  rsp_cell_byte,
   output logic        rsp_last_write,
   output logic [12:0] rsp_cursor_after
);

   localparam int AW = tccw_pkg::ADDR_W;
   localparam int CW = tccw_pkg::COL_W;

   // Sequencer state.
   tccw_pkg::step_type     pc_ff, pc_in;
   tccw_pkg::ctl_word_type ctl;

   // Datapath registers.
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    char_ff;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;
   logic [AW-1:0] rsp_after_ff;

   logic          out_free;
   logic          fire;
   logic          req_take;
   logic          is_newline;
   logic          is_nul;
   logic          count_last;

   logic [AW:0]   cur_inc;
   logic          cur_wrap;
   logic [AW-1:0] cur_next;
   logic [CW-1:0] col_next;
   logic [AW:0]   nl_sum;
   logic [AW-1:0] nl_start;
   logic [AW:0]   clr_inc;
   logic [AW-1:0] clr_next;

   assign ctl = tccw_pkg::rom_word(pc_ff);

   // The output register is free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // A step that writes a result only goes ahead when the register can take it.
   assign fire     = !ctl.emit || out_free;

   assign req_stall  = !ctl.take;
   assign req_take   = req_valid && ctl.take;
   assign is_newline = (req_char_code == tccw_pkg::CR_CODE) ||
                       (req_char_code == tccw_pkg::LF_CODE);
   assign is_nul     = (req_char_code == tccw_pkg::NUL_CODE);
   assign count_last = (count_ff == CW'(tccw_pkg::COLUMNS - 1));

   // Cursor advance for an ordinary character, wrapping at the end of the screen.
   assign cur_inc  = {1'b0, cursor_ff} + (AW+1)'(1);
   assign cur_wrap = (cur_inc == (AW+1)'(tccw_pkg::CELLS));
   assign cur_next = cur_wrap ? '0 : cur_inc[AW-1:0];
   assign col_next = (cur_wrap || col_ff == CW'(tccw_pkg::COLUMNS - 1)) ? '0
                                                                       : col_ff + CW'(1);

   // Start of the next row, back to row 0 past the last row.
   assign nl_sum   = {1'b0, row_base_ff} + (AW+1)'(tccw_pkg::COLUMNS);
   assign nl_start = (nl_sum >= (AW+1)'(tccw_pkg::CELLS))
                     ? AW'(nl_sum - (AW+1)'(tccw_pkg::CELLS))
                     : nl_sum[AW-1:0];

   // Clearing address walks along the row, wrapping at the end of the screen.
   assign clr_inc  = {1'b0, clr_addr_ff} + (AW+1)'(1);
   assign clr_next = (clr_inc == (AW+1)'(tccw_pkg::CELLS)) ? '0 : clr_inc[AW-1:0];

   // Next step selection.
   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         case (ctl.seq)
            tccw_pkg::SEQ_NEXT: begin
               pc_in = pc_ff + tccw_pkg::step_type'(1);
            end
            tccw_pkg::SEQ_JUMP: begin
               pc_in = ctl.target;
            end
            tccw_pkg::SEQ_DISPATCH: begin
               if (!req_take || is_nul) begin
                  pc_in = pc_ff;
               end else if (is_newline) begin
                  pc_in = ctl.target;
               end else begin
                  pc_in = pc_ff + tccw_pkg::step_type'(1);
               end
            end
            tccw_pkg::SEQ_LOOP: begin
               pc_in = count_last ? tccw_pkg::STEP_FETCH : ctl.target;
            end
            default: begin
               pc_in = tccw_pkg::STEP_FETCH;
            end
         endcase
      end
   end

   // Datapath updates, one operation per control word.
   always_comb begin
      cursor_in   = cursor_ff;
      row_base_in = row_base_ff;
      col_in      = col_ff;
      clr_addr_in = clr_addr_ff;
      count_in    = count_ff;
      if (fire) begin
         unique case (ctl.op)
            tccw_pkg::OP_TAKE: begin
            end
            tccw_pkg::OP_PUTC: begin
               cursor_in = cur_next;
               col_in    = col_next;
               if (cur_wrap) begin
                  row_base_in = '0;
               end else if (col_ff == CW'(tccw_pkg::COLUMNS - 1)) begin
                  row_base_in = cur_inc[AW-1:0];
               end
            end
            tccw_pkg::OP_NEWLINE: begin
               cursor_in   = nl_start;
               row_base_in = nl_start;
               col_in      = '0;
               clr_addr_in = nl_start;
               count_in    = '0;
            end
            tccw_pkg::OP_CLEAR: begin
               clr_addr_in = clr_next;
               count_in    = count_ff + CW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.emit && fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= tccw_pkg::STEP_FETCH;
         cursor_ff    <= '0;
         row_base_ff  <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cursor_ff    <= cursor_in;
         row_base_ff  <= row_base_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_addr_ff <= clr_addr_in;
      count_ff    <= count_in;
      if (req_take) begin
         char_ff <= req_char_code;
      end
      if (ctl.emit && fire) begin
         if (ctl.op == tccw_pkg::OP_PUTC) begin
            rsp_addr_ff  <= cursor_ff;
            rsp_byte_ff  <= char_ff;
            rsp_last_ff  <= 1'b1;
            rsp_after_ff <= cur_next;
         end else begin
            rsp_addr_ff  <= clr_addr_ff;
            rsp_byte_ff  <= tccw_pkg::SPACE_CODE;
            rsp_last_ff  <= count_last;
            rsp_after_ff <= cursor_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_address = rsp_addr_ff;
   assign rsp_cell_byte    = rsp_byte_ff;
   assign rsp_last_write   = rsp_last_ff;
   assign rsp_cursor_after = rsp_after_ff;

   // The cursor always sits inside the screen and agrees with its row base and column.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff < AW'(tccw_pkg::CELLS))
      else $error("cursor outside the screen");

   a_cursor_split: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cursor_ff} == {1'b0, row_base_ff} + (AW+1)'(col_ff)) &&
      (col_ff < CW'(tccw_pkg::COLUMNS)))
      else $error("cursor does not match row base and column");

   // A beat that is not a space can only be the single write of an ordinary byte.
   a_char_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cell_byte != tccw_pkg::SPACE_CODE) |-> rsp_last_write)
      else $error("character write not marked as last");

   // Each clearing write that goes ahead moves the count on by one.
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == tccw_pkg::STEP_CLEAR) && fire && !count_last
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("clearing count did not advance");

endmodule

### test/tb.sv
// Self-checking testbench for the text console cursor writer top level.
`timescale 1ns / 1ps

module tb;

   // Number of text rows on the screen; the walk to the bottom row relies on it.
   localparam int ROWS = tccw_pkg::CELLS / tccw_pkg::COLUMNS;

   // The watchdog limit lies far above the longest quiet stretch of a correct run: a
   // newline passes its fetch and row set-up steps before its first clearing write,
   // and random idling and stalling on either channel break off at random.
   localparam int WATCHDOG_LIMIT = 2000;

   // A newline keeps the block busy through its row set-up and a row of clearing
   // writes; the run waits longer than that once the last expected write has arrived.
   localparam int DRAIN_CYCLES = 60;

   localparam int RANDOM_ITEMS = 350;
   localparam int IDLE_PERCENT = 10;

   // How a row of the directed table is checked.
   typedef enum logic [1:0] {
      ROW_PREDICT = 2'd0,
      ROW_WRITE   = 2'd1,
      ROW_SILENT  = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   code;
      logic [12:0]  address;
      logic [7:0]   cell_byte;
      logic [12:0]  after;
   } directed_row_type;

   typedef struct packed {
      logic [12:0] address;
      logic [7:0]  cell_byte;
      logic        last;
      logic [12:0] after;
   } cell_write_type;

   localparam int DIRECTED_ROWS = 18;

   // Rows marked ROW_WRITE carry the single write that the byte must give, read
   // straight off the behaviour from reset; the others go through the predictor.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_WRITE,   8'h41,                13'd0,   8'h41,                13'd1},
      '{ROW_SILENT,  tccw_pkg::NUL_CODE,   13'd0,   8'h00,                13'd0},
      '{ROW_WRITE,   8'hFF,                13'd1,   8'hFF,                13'd2},
      '{ROW_WRITE,   8'h80,                13'd2,   8'h80,                13'd3},
      '{ROW_WRITE,   8'h7F,                13'd3,   8'h7F,                13'd4},
      '{ROW_WRITE,   8'h01,                13'd4,   8'h01,                13'd5},
      '{ROW_PREDICT, tccw_pkg::CR_CODE,    13'd0,   8'h00,                13'd0},
      '{ROW_SILENT,  tccw_pkg::NUL_CODE,   13'd0,   8'h00,                13'd0},
      '{ROW_PREDICT, tccw_pkg::LF_CODE,    13'd0,   8'h00,                13'd0},
      '{ROW_PREDICT, tccw_pkg::LF_CODE,    13'd0,   8'h00,                13'd0},
      '{ROW_WRITE,   tccw_pkg::SPACE_CODE, 13'd120, tccw_pkg::SPACE_CODE, 13'd121},
      '{ROW_WRITE,   8'h0B,                13'd121, 8'h0B,                13'd122},
      '{ROW_WRITE,   8'h0C,                13'd122, 8'h0C,                13'd123},
      '{ROW_WRITE,   8'h0E,                13'd123, 8'h0E,                13'd124},
      '{ROW_WRITE,   8'h09,                13'd124, 8'h09,                13'd125},
      '{ROW_PREDICT, 8'hAA,                13'd0,   8'h00,                13'd0},
      '{ROW_PREDICT, 8'h55,                13'd0,   8'h00,                13'd0},
      '{ROW_PREDICT, tccw_pkg::CR_CODE,    13'd0,   8'h00,                13'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [12:0] rsp_cell_address;
   logic [7:0]  rsp_cell_byte;
   logic        rsp_last_write;
   logic [12:0] rsp_cursor_after;

   // Writes still owed by the block, oldest first.
   cell_write_type pending_writes [$];

   // The cursor as the predictor sees it after every accepted byte.
   int unsigned cursor_model = 0;

   int error_count = 0;
   int chars_taken = 0;
   int quiet_cycles = 0;

   // While set, neither side idles, giving a long stretch at full rate.
   logic calm = 1'b0;

   text_console_cursor_writer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_address (rsp_cell_address),
      .rsp_cell_byte    (rsp_cell_byte),
      .rsp_last_write   (rsp_last_write),
      .rsp_cursor_after (rsp_cursor_after)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor. A zero byte leaves everything alone. A newline moves the cursor to
   // the start of the next row, wrapping to row 0 from the bottom row, and clears
   // that row with spaces. Any other byte is written at the cursor, which then
   // moves on by one and wraps at the end of the screen. With enqueue low only the
   // cursor is moved, for rows whose write is typed into the table.
   task automatic predict_writes(input logic [7:0] code, input bit enqueue);
      cell_write_type w;
      int unsigned row_start;
      if (code == tccw_pkg::CR_CODE || code == tccw_pkg::LF_CODE) begin
         row_start = ((cursor_model / tccw_pkg::COLUMNS) * tccw_pkg::COLUMNS
                      + tccw_pkg::COLUMNS) % tccw_pkg::CELLS;
         cursor_model = row_start;
         for (int k = 0; k < tccw_pkg::COLUMNS; k++) begin
            w.address   = 13'((row_start + k) % tccw_pkg::CELLS);
            w.cell_byte = tccw_pkg::SPACE_CODE;
            w.last      = (k == tccw_pkg::COLUMNS - 1);
            w.after     = 13'(row_start);
            if (enqueue) pending_writes.push_back(w);
         end
      end else if (code != tccw_pkg::NUL_CODE) begin
         w.address    = 13'(cursor_model);
         w.cell_byte  = code;
         w.last       = 1'b1;
         cursor_model = (cursor_model + 1) % tccw_pkg::CELLS;
         w.after      = 13'(cursor_model);
         if (enqueue) pending_writes.push_back(w);
      end
   endtask

   // Offers one byte on the request channel and returns at the edge that takes it.
   // Before the beat the sender may idle at random, with the payload scrambled
   // since it is not valid then.
   task automatic send_char(input logic [7:0] code, input bit enqueue);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid     <= 1'b0;
         req_char_code <= 8'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      predict_writes(code, enqueue);
      if (code != tccw_pkg::NUL_CODE) chars_taken++;
   endtask

   function automatic logic [7:0] random_printable();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == tccw_pkg::CR_CODE || c == tccw_pkg::LF_CODE);
      return c;
   endfunction

   function automatic logic [7:0] random_newline();
      return $urandom_range(0, 1) ? tccw_pkg::CR_CODE : tccw_pkg::LF_CODE;
   endfunction

   // Sends newlines until the cursor sits at the start of the bottom row.
   task automatic walk_to_last_row();
      while (cursor_model / tccw_pkg::COLUMNS != ROWS - 1)
         send_char(random_newline(), 1'b1);
   endtask

   // The result channel stalls at random, except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Every accepted write is held against the oldest expectation, field by field.
   always @(posedge clock) begin
      cell_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected cell write: cell_address %0d, cell_byte %0h",
                   rsp_cell_address, rsp_cell_byte);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_cell_address !== want.address) begin
               $error("cell_address: expected %0d, actual %0d",
                      want.address, rsp_cell_address);
               error_count++;
            end
            if (rsp_cell_byte !== want.cell_byte) begin
               $error("cell_byte: expected %0h, actual %0h",
                      want.cell_byte, rsp_cell_byte);
               error_count++;
            end
            if (rsp_last_write !== want.last) begin
               $error("last_write: expected %0b, actual %0b",
                      want.last, rsp_last_write);
               error_count++;
            end
            if (rsp_cursor_after !== want.after) begin
               $error("cursor_after: expected %0d, actual %0d",
                      want.after, rsp_cursor_after);
               error_count++;
            end
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int pick;
      int len;
      bit wrapped_row;
      bit wrapped_cell;
      cell_write_type typed;

      wrapped_row  = 1'b0;
      wrapped_cell = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes of the byte, zero bytes, both newline codes, bytes
      // next to the newline codes and a space, all from the reset cursor.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            typed.address   = directed_rows[i].address;
            typed.cell_byte = directed_rows[i].cell_byte;
            typed.last      = 1'b1;
            typed.after     = directed_rows[i].after;
            pending_writes.push_back(typed);
            send_char(directed_rows[i].code, 1'b0);
         end else begin
            send_char(directed_rows[i].code, 1'b1);
         end
      end

      // Random part. Most of it is text shaped like lines: runs of printable bytes,
      // some longer than a row, closed by a newline or a string terminator, and runs
      // of empty lines. A little is pure noise. Twice the cursor is walked down to the
      // bottom row: once to see a newline there wrap to row 0, and once to see a long
      // line run past the last cell and wrap to cell 0.
      chars_taken = 0;
      while (chars_taken < RANDOM_ITEMS) begin
         calm <= (chars_taken >= 150 && chars_taken < 200);
         if (!wrapped_row && chars_taken >= 60) begin
            walk_to_last_row();
            repeat ($urandom_range(0, 10)) send_char(random_printable(), 1'b1);
            send_char(random_newline(), 1'b1);
            wrapped_row = 1'b1;
         end else if (!wrapped_cell && chars_taken >= 220) begin
            walk_to_last_row();
            repeat (tccw_pkg::COLUMNS + 5) send_char(random_printable(), 1'b1);
            wrapped_cell = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               len = $urandom_range(0, tccw_pkg::COLUMNS + 5);
               repeat (len) send_char(random_printable(), 1'b1);
               if ($urandom_range(0, 4) == 0) send_char(tccw_pkg::NUL_CODE, 1'b1);
               else send_char(random_newline(), 1'b1);
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 6)) send_char(random_newline(), 1'b1);
            end else begin
               repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b1);
            end
         end
      end
      calm      <= 1'b0;
      req_valid <= 1'b0;

      // Let every owed write arrive, then give the block time to show any stray one.
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### text_console_cursor_writer_top.f
design/tccw_pkg.sv
design/text_console_cursor_writer_top.sv
test/tb.sv
